/* design/ltdm_pkg.sv */
// Shared types, constants and helpers of the link timeline delay model.
`default_nettype none

package ltdm_pkg;

    localparam int WORD_W      = 64;
    localparam int LEN_W       = 32;
    localparam int LAT_W       = 36;
    localparam int EP_W        = 32;
    localparam int DIGIT_W     = 8;
    localparam int TAIL_DIGITS = WORD_W / DIGIT_W;
    localparam int DIV_STEPS   = WORD_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int BIT_IDX_W   = $clog2(WORD_W);
    localparam int CFG_IDX_W   = 2;

    // 8e9 = 1953125 * 2^12, so the scaling is a narrow constant product and a shift.
    localparam logic [WORD_W-1:0] NS_SCALE      = 64'd8000000000;
    localparam int                NS_SHIFT      = 12;
    localparam int                ODD_W         = 21;
    localparam logic [ODD_W-1:0]  NS_SCALE_ODD  = ODD_W'(NS_SCALE >> NS_SHIFT);
    localparam logic [WORD_W-1:0] WORD_MAX      = '1;
    localparam logic [LEN_W-1:0]  LEN_LIMIT     = LEN_W'(WORD_MAX / NS_SCALE);
    localparam logic [WORD_W-1:0] STALE_LIMIT_NS = 64'd60000000000;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_CAS   = 2'd2,
        OP_FADD  = 2'd3
    } op_e;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_OVERFLOW   = 2'd1,
        STATUS_FUNCTIONAL = 2'd2
    } status_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMED_MODE    = 2'd0,
        CFG_FIXED_LATENCY = 2'd1,
        CFG_BANDWIDTH     = 2'd2,
        CFG_OVERHEAD      = 2'd3
    } cfg_index_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_TLOAD,
        ST_TAIL,
        ST_COMMIT
    } ltdm_state_e;

    typedef struct packed {
        logic [1:0]        op;
        logic [LEN_W-1:0]  length_bytes;
        logic [EP_W-1:0]   local_endpoint;
        logic [EP_W-1:0]   remote_endpoint;
        logic [WORD_W-1:0] submit_time;
        logic [WORD_W-1:0] now_time;
    } s_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              direction;
        logic [WORD_W-1:0] serialize_ns;
        logic [WORD_W-1:0] start_time;
        logic [WORD_W-1:0] deadline_time;
        logic [WORD_W-1:0] planned_delay;
        logic [WORD_W-1:0] service_ns;
        logic [WORD_W-1:0] total_operations;
        logic [WORD_W-1:0] total_bytes;
        logic [WORD_W-1:0] total_planned;
    } m_item_t;

    typedef struct packed {
        logic load_div;
        logic step_div;
        logic load_tail;
        logic step_tail;
    } ltdm_ctrl_t;

    typedef struct packed {
        logic submit_nz;
        logic submit_gt_now;
        logic stale;
        logic ready_gt_submit;
        logic ready_gt_now;
    } stamp_flags_t;

    typedef struct packed {
        logic [WORD_W-1:0] quotient;
        logic              round_up;
        logic              use_now;
        logic              take_ready;
        logic [WORD_W-1:0] now_time;
        logic [WORD_W-1:0] submit_time;
        logic [WORD_W-1:0] ready_time;
        logic [LAT_W-1:0]  fixed_latency;
        logic [LAT_W-1:0]  overhead;
        logic [LEN_W-1:0]  length;
        logic [WORD_W-1:0] op_count;
        logic [WORD_W-1:0] byte_sum;
        logic [WORD_W-1:0] service_sum;
        logic [WORD_W-1:0] planned_sum;
    } tail_load_t;

    typedef struct packed {
        logic [WORD_W-1:0] serialize;
        logic [WORD_W-1:0] start;
        logic [WORD_W-1:0] deadline;
        logic [WORD_W-1:0] planned;
        logic [WORD_W-1:0] base;
        logic [WORD_W-1:0] ready_next;
        logic [WORD_W-1:0] op_count;
        logic [WORD_W-1:0] byte_sum;
        logic [WORD_W-1:0] service_sum;
        logic [WORD_W-1:0] planned_sum;
        logic              overflow;
    } tail_res_t;

    // One digit of a ripple adder: returns the carry out above the sum digit.
    function automatic logic [DIGIT_W:0] digit_add(
        input logic [DIGIT_W-1:0] a,
        input logic [DIGIT_W-1:0] b,
        input logic               cin
    );
        digit_add = {1'b0, a} + {1'b0, b} + {{DIGIT_W{1'b0}}, cin};
    endfunction

endpackage

`default_nettype wire

/* design/ltdm_divider.sv */
// Radix-2 restoring divider producing one quotient bit per cycle while step_div is set.
`default_nettype none

module ltdm_divider
    import ltdm_pkg::*;
(
    input  logic              aclk,
    input  ltdm_ctrl_t        ctrl,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic [WORD_W-1:0] quotient,
    output logic              rem_nz
);

    logic [WORD_W-1:0] dvd_reg, dvd_next;
    logic [WORD_W-1:0] dsr_reg, dsr_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W:0]   partial;
    logic [WORD_W+1:0] trial;
    logic              dsr_nz;
    logic              take;

    assign dsr_nz = |dsr_reg;

    always_comb begin
        partial  = {rem_reg, dvd_reg[WORD_W-1]};
        trial    = {1'b0, partial} - {2'b00, dsr_reg};
        // A zero divisor never subtracts, so the quotient stays zero and rem_nz is held low.
        take     = dsr_nz && !trial[WORD_W+1];
        dvd_next = dvd_reg;
        dsr_next = dsr_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (ctrl.load_div) begin
            dvd_next = dividend;
            dsr_next = divisor;
            quo_next = '0;
            rem_next = '0;
        end else if (ctrl.step_div) begin
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            quo_next = {quo_reg[WORD_W-2:0], take};
            rem_next = take ? trial[WORD_W-1:0] : partial[WORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient = quo_reg;
    assign rem_nz   = dsr_nz && (rem_reg != '0);

endmodule

`default_nettype wire

/* design/ltdm_stamp_cmp.sv */
// Bit-serial timestamp comparator that classifies the submit stamp and ready time.
`default_nettype none

module ltdm_stamp_cmp
    import ltdm_pkg::*;
(
    input  logic              aclk,
    input  ltdm_ctrl_t        ctrl,
    input  logic [WORD_W-1:0] now_time,
    input  logic [WORD_W-1:0] submit_time,
    input  logic [WORD_W-1:0] ready_time,
    output stamp_flags_t      flags
);

    logic [WORD_W-1:0]    now_sr, sub_sr, rdy_sr;
    logic [BIT_IDX_W-1:0] idx_reg;
    logic                 borrow_reg, borrow_next;
    logic                 nz_reg, stale_reg, stale_next, rgs_reg, rgn_reg;
    logic                 n_bit, s_bit, r_bit, d_bit;

    // Words are examined least significant bit first; a later differing bit wins.
    always_comb begin
        n_bit       = now_sr[0];
        s_bit       = sub_sr[0];
        r_bit       = rdy_sr[0];
        d_bit       = n_bit ^ s_bit ^ borrow_reg;
        borrow_next = (!n_bit && s_bit) || (!(n_bit ^ s_bit) && borrow_reg);
        stale_next  = (d_bit != STALE_LIMIT_NS[idx_reg]) ? d_bit : stale_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_div) begin
            now_sr     <= now_time;
            sub_sr     <= submit_time;
            rdy_sr     <= ready_time;
            idx_reg    <= '0;
            borrow_reg <= 1'b0;
            nz_reg     <= 1'b0;
            stale_reg  <= 1'b0;
            rgs_reg    <= 1'b0;
            rgn_reg    <= 1'b0;
        end else if (ctrl.step_div) begin
            now_sr     <= {1'b0, now_sr[WORD_W-1:1]};
            sub_sr     <= {1'b0, sub_sr[WORD_W-1:1]};
            rdy_sr     <= {1'b0, rdy_sr[WORD_W-1:1]};
            idx_reg    <= idx_reg + 1'b1;
            borrow_reg <= borrow_next;
            nz_reg     <= nz_reg | s_bit;
            stale_reg  <= stale_next;
            rgs_reg    <= (r_bit != s_bit) ? r_bit : rgs_reg;
            rgn_reg    <= (r_bit != n_bit) ? r_bit : rgn_reg;
        end
    end

    assign flags.submit_nz       = nz_reg;
    assign flags.submit_gt_now   = borrow_reg;
    assign flags.stale           = stale_reg;
    assign flags.ready_gt_submit = rgs_reg;
    assign flags.ready_gt_now    = rgn_reg;

endmodule

`default_nettype wire

/* design/ltdm_timeline.sv */
// Digit-serial adder chain that builds the timeline, statistics and overflow flag.
`default_nettype none

module ltdm_timeline
    import ltdm_pkg::*;
(
    input  logic       aclk,
    input  ltdm_ctrl_t ctrl,
    input  tail_load_t ld,
    output tail_res_t  res
);

    typedef struct packed {
        logic ser;
        logic rdy;
        logic lat;
        logic ovh;
        logic pln;
        logic bs1;
        logic bs2;
        logic cnt;
        logic byt;
        logic svc;
        logic pls;
    } tail_carry_t;

    logic [WORD_W-1:0] quo_sr, now_sr, sub_sr, rdy_sr, fix_sr, ovh_sr, len_sr;
    logic [WORD_W-1:0] cnt_sr, byt_sr, svc_sr, pls_sr;
    logic [WORD_W-1:0] ser_acc, start_acc, dl_acc, pl_acc, base_acc, rnx_acc;
    logic [WORD_W-1:0] cnt_acc, byt_acc, svc_acc, pls_acc;
    logic              use_now_reg, take_ready_reg;
    logic              all_ones_reg, all_ones_next;
    tail_carry_t       cy_reg, cy_next, cy_init;
    logic [DIGIT_W-1:0] eff_d, start_d, ser_d, rnx_d, lat_d, dl_d, pl_d;
    logic [DIGIT_W-1:0] b1_d, base_d, cnt_d, byt_d, svc_d, pls_d;

    // Carry-ins of the first digit: the round-up of the quotient, the +1 of the
    // subtraction and the operation count increment.
    always_comb begin
        cy_init     = '0;
        cy_init.ser = ld.round_up;
        cy_init.pln = 1'b1;
        cy_init.cnt = 1'b1;
    end

    always_comb begin
        eff_d   = use_now_reg ? now_sr[DIGIT_W-1:0] : sub_sr[DIGIT_W-1:0];
        start_d = take_ready_reg ? rdy_sr[DIGIT_W-1:0] : eff_d;
        {cy_next.ser, ser_d}  = digit_add(quo_sr[DIGIT_W-1:0], '0, cy_reg.ser);
        {cy_next.rdy, rnx_d}  = digit_add(start_d, ser_d, cy_reg.rdy);
        {cy_next.lat, lat_d}  = digit_add(rnx_d, fix_sr[DIGIT_W-1:0], cy_reg.lat);
        {cy_next.ovh, dl_d}   = digit_add(lat_d, ovh_sr[DIGIT_W-1:0], cy_reg.ovh);
        // Deadline minus effective submit, as an add of the complement.
        {cy_next.pln, pl_d}   = digit_add(dl_d, ~eff_d, cy_reg.pln);
        {cy_next.bs1, b1_d}   = digit_add(ser_d, fix_sr[DIGIT_W-1:0], cy_reg.bs1);
        {cy_next.bs2, base_d} = digit_add(b1_d, ovh_sr[DIGIT_W-1:0], cy_reg.bs2);
        {cy_next.cnt, cnt_d}  = digit_add(cnt_sr[DIGIT_W-1:0], '0, cy_reg.cnt);
        {cy_next.byt, byt_d}  = digit_add(byt_sr[DIGIT_W-1:0], len_sr[DIGIT_W-1:0],
                                          cy_reg.byt);
        {cy_next.svc, svc_d}  = digit_add(svc_sr[DIGIT_W-1:0], base_d, cy_reg.svc);
        {cy_next.pls, pls_d}  = digit_add(pls_sr[DIGIT_W-1:0], pl_d, cy_reg.pls);
        all_ones_next = all_ones_reg && (&ser_d);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_tail) begin
            quo_sr         <= ld.quotient;
            now_sr         <= ld.now_time;
            sub_sr         <= ld.submit_time;
            rdy_sr         <= ld.ready_time;
            fix_sr         <= WORD_W'(ld.fixed_latency);
            ovh_sr         <= WORD_W'(ld.overhead);
            len_sr         <= WORD_W'(ld.length);
            cnt_sr         <= ld.op_count;
            byt_sr         <= ld.byte_sum;
            svc_sr         <= ld.service_sum;
            pls_sr         <= ld.planned_sum;
            use_now_reg    <= ld.use_now;
            take_ready_reg <= ld.take_ready;
            all_ones_reg   <= 1'b1;
            cy_reg         <= cy_init;
        end else if (ctrl.step_tail) begin
            quo_sr       <= quo_sr >> DIGIT_W;
            now_sr       <= now_sr >> DIGIT_W;
            sub_sr       <= sub_sr >> DIGIT_W;
            rdy_sr       <= rdy_sr >> DIGIT_W;
            fix_sr       <= fix_sr >> DIGIT_W;
            ovh_sr       <= ovh_sr >> DIGIT_W;
            len_sr       <= len_sr >> DIGIT_W;
            cnt_sr       <= cnt_sr >> DIGIT_W;
            byt_sr       <= byt_sr >> DIGIT_W;
            svc_sr       <= svc_sr >> DIGIT_W;
            pls_sr       <= pls_sr >> DIGIT_W;
            cy_reg       <= cy_next;
            all_ones_reg <= all_ones_next;
            ser_acc      <= {ser_d, ser_acc[WORD_W-1:DIGIT_W]};
            start_acc    <= {start_d, start_acc[WORD_W-1:DIGIT_W]};
            dl_acc       <= {dl_d, dl_acc[WORD_W-1:DIGIT_W]};
            pl_acc       <= {pl_d, pl_acc[WORD_W-1:DIGIT_W]};
            base_acc     <= {base_d, base_acc[WORD_W-1:DIGIT_W]};
            rnx_acc      <= {rnx_d, rnx_acc[WORD_W-1:DIGIT_W]};
            cnt_acc      <= {cnt_d, cnt_acc[WORD_W-1:DIGIT_W]};
            byt_acc      <= {byt_d, byt_acc[WORD_W-1:DIGIT_W]};
            svc_acc      <= {svc_d, svc_acc[WORD_W-1:DIGIT_W]};
            pls_acc      <= {pls_d, pls_acc[WORD_W-1:DIGIT_W]};
        end
    end

    // After the last digit the carries held are those out of the top digit.
    assign res.serialize   = ser_acc;
    assign res.start       = start_acc;
    assign res.deadline    = dl_acc;
    assign res.planned     = pl_acc;
    assign res.base        = base_acc;
    assign res.ready_next  = rnx_acc;
    assign res.op_count    = cnt_acc;
    assign res.byte_sum    = byt_acc;
    assign res.service_sum = svc_acc;
    assign res.planned_sum = pls_acc;
    assign res.overflow    = cy_reg.rdy | cy_reg.lat | cy_reg.ovh | all_ones_reg;

endmodule

`default_nettype wire

/* design/link_timeline_delay_model.sv */
// Top level of the link timeline delay model: control, state, configuration and ports.
// Timed transaction: the 64-step radix-2 divider forms the serialisation delay and the adder
// chain the timeline; no new transaction is taken until the result has been published.
// Functional transaction: the result is published straight from idle; none is taken meanwhile.
// A result waits in the output register while the next transaction is being accepted.
// Synchronous active-low reset clears configuration, link ready times and statistics.
`default_nettype none

module link_timeline_delay_model
    import ltdm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  s_item_t              s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output m_item_t              m_item
);

    // Configuration registers.
    logic              timed_mode_reg;
    logic [LAT_W-1:0]  fixed_lat_reg;
    logic [WORD_W-1:0] bw_reg;
    logic [LAT_W-1:0]  overhead_reg;

    // Architectural state: per-direction ready times and the statistics counters.
    logic [WORD_W-1:0] ready0_reg, ready1_reg;
    logic [WORD_W-1:0] op_count_reg, byte_sum_reg, service_sum_reg, planned_sum_reg;

    // The transaction being worked on.
    logic [1:0]        op_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [WORD_W-1:0] submit_reg, now_reg;
    logic              dir_reg, func_reg;

    ltdm_state_e       state_reg, state_next;
    logic [STEP_W-1:0] step_cnt_reg, step_cnt_next;
    logic              m_valid_reg, m_valid_next;
    m_item_t           m_item_reg, m_item_next;

    ltdm_ctrl_t             ctrl;
    logic                   out_load;
    logic                   accept;
    logic                   commit_ok;
    logic                   prod_ovf;
    logic                   use_now;
    logic [LEN_W+ODD_W-1:0] prod;
    logic [WORD_W-1:0]      dividend;
    logic [WORD_W-1:0]      ready_sel;
    logic [WORD_W-1:0]      quotient;
    logic                   rem_nz;
    stamp_flags_t           flags;
    tail_load_t             tl_load;
    tail_res_t              tl_res;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Length times 8e9 is length times 5^9, shifted up by twelve places. Lengths above the
    // limit do not fit in 64 bits; with no bandwidth an oversized length is not flagged as overflow.
    assign prod      = {{ODD_W{1'b0}}, len_reg} * {{LEN_W{1'b0}}, NS_SCALE_ODD};
    assign dividend  = {prod[WORD_W-NS_SHIFT-1:0], {NS_SHIFT{1'b0}}};
    assign prod_ovf  = (len_reg > LEN_LIMIT) && (bw_reg != '0);
    assign ready_sel = dir_reg ? ready1_reg : ready0_reg;

    ltdm_divider u_divider (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .dividend (dividend),
        .divisor  (bw_reg),
        .quotient (quotient),
        .rem_nz   (rem_nz)
    );

    // The stamp comparator runs alongside the divider, one bit a cycle, and settles whether
    // the submit stamp is usable and which of the candidate times is later.
    ltdm_stamp_cmp u_stamp_cmp (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .now_time    (now_reg),
        .submit_time (submit_reg),
        .ready_time  (ready_sel),
        .flags       (flags)
    );

    // Atomics and unknown, future or stale stamps are timed from the current time.
    assign use_now = (op_reg == OP_CAS) || (op_reg == OP_FADD) || !flags.submit_nz ||
                     flags.submit_gt_now || flags.stale;

    always_comb begin
        tl_load.quotient      = quotient;
        tl_load.round_up      = rem_nz;
        tl_load.use_now       = use_now;
        tl_load.take_ready    = use_now ? flags.ready_gt_now : flags.ready_gt_submit;
        tl_load.now_time      = now_reg;
        tl_load.submit_time   = submit_reg;
        tl_load.ready_time    = ready_sel;
        tl_load.fixed_latency = fixed_lat_reg;
        tl_load.overhead      = overhead_reg;
        tl_load.length        = len_reg;
        tl_load.op_count      = op_count_reg;
        tl_load.byte_sum      = byte_sum_reg;
        tl_load.service_sum   = service_sum_reg;
        tl_load.planned_sum   = planned_sum_reg;
    end

    // The rounded-up quotient, the timeline sums and the counter updates are all formed
    // a byte at a time, least significant byte first.
    ltdm_timeline u_timeline (
        .aclk (aclk),
        .ctrl (ctrl),
        .ld   (tl_load),
        .res  (tl_res)
    );

    // Sequencer: load, divide, load the adder chain, run it, then publish; functional mode only publishes.
    always_comb begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        ctrl          = '0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = timed_mode_reg ? ST_LOAD : ST_COMMIT;
                end
            end
            ST_LOAD: begin
                ctrl.load_div = 1'b1;
                step_cnt_next = '0;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                ctrl.step_div = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_TLOAD;
                end
            end
            ST_TLOAD: begin
                ctrl.load_tail = 1'b1;
                step_cnt_next  = '0;
                state_next     = ST_TAIL;
            end
            ST_TAIL: begin
                ctrl.step_tail = 1'b1;
                step_cnt_next  = step_cnt_reg + 1'b1;
                if (step_cnt_reg == STEP_W'(TAIL_DIGITS - 1)) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                // The result waits here only while the previous one has not been taken.
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    // Capture the accepted transaction and choose its link direction straight away.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= s_item.op;
            len_reg    <= s_item.length_bytes;
            submit_reg <= s_item.submit_time;
            now_reg    <= s_item.now_time;
            dir_reg    <= (s_item.op == OP_READ) ? s_item.remote_endpoint[0]
                                                 : s_item.local_endpoint[0];
            func_reg   <= !timed_mode_reg;
        end
    end

    // An overflowing or functional transaction leaves all state alone and reports zeros,
    // apart from the status and the present statistics.
    always_comb begin
        commit_ok   = !func_reg && !prod_ovf && !tl_res.overflow;
        m_item_next = '0;
        m_item_next.total_operations = op_count_reg;
        m_item_next.total_bytes      = byte_sum_reg;
        m_item_next.total_planned    = planned_sum_reg;
        if (commit_ok) begin
            m_item_next.status           = STATUS_OK;
            m_item_next.direction        = dir_reg;
            m_item_next.serialize_ns     = tl_res.serialize;
            m_item_next.start_time       = tl_res.start;
            m_item_next.deadline_time    = tl_res.deadline;
            m_item_next.planned_delay    = tl_res.planned;
            m_item_next.service_ns       = tl_res.base;
            m_item_next.total_operations = tl_res.op_count;
            m_item_next.total_bytes      = tl_res.byte_sum;
            m_item_next.total_planned    = tl_res.planned_sum;
        end else if (func_reg) begin
            m_item_next.status = STATUS_FUNCTIONAL;
        end else begin
            m_item_next.status = STATUS_OVERFLOW;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_item_reg <= m_item_next;
        end
    end

    // Configuration and architectural state. The user must write configuration only while the
    // block is idle, so it holds steady for the whole of a transaction; the block does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timed_mode_reg  <= 1'b0;
            fixed_lat_reg   <= '0;
            bw_reg          <= '0;
            overhead_reg    <= '0;
            ready0_reg      <= '0;
            ready1_reg      <= '0;
            op_count_reg    <= '0;
            byte_sum_reg    <= '0;
            service_sum_reg <= '0;
            planned_sum_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index_e'(cfg_index))
                    CFG_TIMED_MODE:    timed_mode_reg <= cfg_wdata[0];
                    CFG_FIXED_LATENCY: fixed_lat_reg  <= cfg_wdata[LAT_W-1:0];
                    CFG_BANDWIDTH:     bw_reg         <= cfg_wdata;
                    CFG_OVERHEAD:      overhead_reg   <= cfg_wdata[LAT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (out_load && commit_ok) begin
                if (dir_reg) begin
                    ready1_reg <= tl_res.ready_next;
                end else begin
                    ready0_reg <= tl_res.ready_next;
                end
                op_count_reg    <= tl_res.op_count;
                byte_sum_reg    <= tl_res.byte_sum;
                service_sum_reg <= tl_res.service_sum;
                planned_sum_reg <= tl_res.planned_sum;
            end
        end
    end

endmodule

`default_nettype wire

/* design/ltdm_checker.sv */
// Port-level checker for the link timeline delay model, bound to the top level.
`default_nettype none

module ltdm_checker
    import ltdm_pkg::*;
(
    input logic    aclk,
    input logic    aresetn,
    input logic    s_valid,
    input logic    s_ready,
    input logic    m_valid,
    input logic    m_ready,
    input m_item_t m_item
);

    // Only one transaction is worked on at a time.
    a_one_at_a_time: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready
    ) else $error("input accepted while a transaction is still in progress");

    a_result_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_item))
    ) else $error("stalled result changed or was withdrawn");

    a_untimed_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status != STATUS_OK) |->
            (!m_item.direction && m_item.serialize_ns == '0 &&
             m_item.deadline_time == '0 && m_item.planned_delay == '0)
    ) else $error("untimed result carries timing fields");

    a_deadline_sum: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status == STATUS_OK) |->
            (m_item.deadline_time == m_item.start_time + m_item.service_ns &&
             m_item.service_ns >= m_item.serialize_ns)
    ) else $error("deadline does not equal start plus service time");

endmodule

bind link_timeline_delay_model ltdm_checker u_ltdm_checker (.*);

`default_nettype wire
